// ===== src/tou_pkg.sv =====
`timescale 1ns / 1ps
// tou_pkg: shared types, codes and constants of the two-tariff energy split unit
// depends on nothing; used by the interfaces and every module under src
package tou_pkg;

    localparam int ENERGY_BITS = 24;
    localparam int HOUR_BITS   = 5;
    localparam int TOTAL_BITS  = 32;
    localparam int ADDR_BITS   = 3;
    localparam int APB_WIDTH   = 32;

    // first year (since 1900) at which the wall clock counts as set
    localparam logic [7:0] CLOCK_SET_YEAR = 8'd116;

    // item operation codes
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_CLR_PREV  = 2'd1;
    localparam logic [1:0] OP_CLR_ALL   = 2'd2;

    // register indexes (byte address bits [ADDR_BITS-1:2])
    localparam logic REG_DAY_START   = 1'b0;
    localparam logic REG_NIGHT_START = 1'b1;

    localparam logic [HOUR_BITS-1:0] DAY_START_RESET   = 5'd7;
    localparam logic [HOUR_BITS-1:0] NIGHT_START_RESET = 5'd23;

    typedef logic [ENERGY_BITS-1:0] mark_t;
    typedef logic [TOTAL_BITS-1:0]  total_t;

    typedef struct packed {
        mark_t last_midnight;
        mark_t cur_midnight;
        mark_t last_day_start;
        mark_t last_night_start;
        mark_t cur_day_start;
        mark_t cur_night_start;
    } marks_t;

    typedef struct packed {
        logic [HOUR_BITS-1:0] day_start_hour;
        logic [HOUR_BITS-1:0] night_start_hour;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [23:0] energy_reading;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [7:0]  year_since_1900;
    } in_item_t;

    typedef struct packed {
        total_t used_today;
        total_t yesterday_total;
        total_t yesterday_night;
        total_t yesterday_day;
        total_t night_today;
        total_t day_today;
    } out_item_t;

endpackage

// ===== src/tou_tick_if.sv =====
`timescale 1ns / 1ps
// tou_tick_if: valid/ready channel that carries one input item
// depends on tou_pkg for the item type
interface tou_tick_if;
    logic               valid;
    logic               ready;
    tou_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tou_total_if.sv =====
`timescale 1ns / 1ps
// tou_total_if: valid/ready channel that carries one result item
// depends on tou_pkg for the result type
interface tou_total_if;
    logic                valid;
    logic                ready;
    tou_pkg::out_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/time_of_use_energy_split_unit.sv =====
`timescale 1ns / 1ps
// time_of_use_energy_split_unit: top level of the day/night energy split
// depends on tou_pkg, tou_tick_if, tou_total_if, tou_regs and tou_calc
//
//   channel   dir   handshake          payload
//   tick      in    valid/ready        op, energy_reading, hour, minute, second, year
//   totals    out   valid/ready        six 32-bit consumption totals
//   apb       in    psel/penable       day_start_hour, night_start_hour
//
// one item per cycle sustained while the totals receiver keeps ready up; an item goes
// from the tick transfer to the totals transfer through the input register, then the
// mark/total update into the result register. the whole update is one pass of tou_calc.
// reset clears the marks, the totals and both valid flags; the hours go to 7 and 23.
// when the result waits, the input register still takes one more item, after
// which tick.ready drops until the totals transfer happens.
module time_of_use_energy_split_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    tou_tick_if.sink                      tick,
    tou_total_if.source                   totals,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tou_pkg::ADDR_BITS-1:0] paddr,
    input  logic [tou_pkg::APB_WIDTH-1:0] pwdata,
    output logic [tou_pkg::APB_WIDTH-1:0] prdata,
    output logic                          pready
);

    tou_pkg::cfg_t       cfg;

    // input stage
    logic                in_valid_reg;
    logic                in_valid_next;
    tou_pkg::in_item_t   in_item_reg;

    // state; totals_reg doubles as the result register since it only changes
    // when the pending result has gone out
    tou_pkg::marks_t     marks_reg;
    tou_pkg::marks_t     marks_next;
    tou_pkg::out_item_t  totals_reg;
    tou_pkg::out_item_t  totals_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                tick_xfer;
    logic                advance;

    tou_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tou_calc u_calc (
        .item        (in_item_reg),
        .cfg         (cfg),
        .marks       (marks_reg),
        .totals      (totals_reg),
        .marks_next  (marks_next),
        .totals_next (totals_next)
    );

    // the held item moves on when the result slot is free or being emptied
    assign advance    = in_valid_reg & (~out_valid_reg | totals.ready);
    assign tick.ready = ~in_valid_reg | advance;
    assign tick_xfer  = tick.valid & tick.ready;

    assign in_valid_next  = tick_xfer | (in_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & ~totals.ready);

    assign totals.valid = out_valid_reg;
    assign totals.data  = totals_reg;

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            marks_reg     <= '0;
            totals_reg    <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                marks_reg  <= marks_next;
                totals_reg <= totals_next;
            end
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            in_item_reg <= tick.data;
        end
    end

endmodule

// ===== src/tou_regs.sv =====
`timescale 1ns / 1ps
// tou_regs: apb register file holding the tariff start hours
// depends on tou_pkg for the register codes and the cfg_t struct
module tou_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tou_pkg::ADDR_BITS-1:0] paddr,
    input  logic [tou_pkg::APB_WIDTH-1:0] pwdata,
    output logic [tou_pkg::APB_WIDTH-1:0] prdata,
    output logic                          pready,
    output tou_pkg::cfg_t                 cfg
);

    logic                             wr_en;
    logic                             reg_idx;
    logic [tou_pkg::HOUR_BITS-1:0]    day_start_reg;
    logic [tou_pkg::HOUR_BITS-1:0]    night_start_reg;
    logic [tou_pkg::HOUR_BITS-1:0]    rd_value;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_start_reg   <= tou_pkg::DAY_START_RESET;
            night_start_reg <= tou_pkg::NIGHT_START_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                tou_pkg::REG_DAY_START:   day_start_reg   <= pwdata[tou_pkg::HOUR_BITS-1:0];
                tou_pkg::REG_NIGHT_START: night_start_reg <= pwdata[tou_pkg::HOUR_BITS-1:0];
                default:                  day_start_reg   <= day_start_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            tou_pkg::REG_DAY_START:   rd_value = day_start_reg;
            tou_pkg::REG_NIGHT_START: rd_value = night_start_reg;
            default:                  rd_value = '0;
        endcase
    end

    assign prdata = tou_pkg::APB_WIDTH'(rd_value);

    assign cfg.day_start_hour   = day_start_reg;
    assign cfg.night_start_hour = night_start_reg;

endmodule

// ===== src/tou_calc.sv =====
`timescale 1ns / 1ps
// tou_calc: single-pass update of the meter marks and the six totals for one item
// depends on tou_pkg for item, mark, total and config types
module tou_calc (
    input  tou_pkg::in_item_t   item,
    input  tou_pkg::cfg_t       cfg,
    input  tou_pkg::marks_t     marks,
    input  tou_pkg::out_item_t  totals,
    output tou_pkg::marks_t     marks_next,
    output tou_pkg::out_item_t  totals_next
);

    tou_pkg::mark_t     e;
    logic               on_hour;
    logic               clock_set;
    logic               real_date;
    tou_pkg::marks_t    filled;
    tou_pkg::marks_t    rolled;
    tou_pkg::marks_t    clamped;
    tou_pkg::mark_t     night_min;
    tou_pkg::total_t    e_w;
    tou_pkg::total_t    pm_w;
    tou_pkg::total_t    tm_w;
    tou_pkg::total_t    pd_w;
    tou_pkg::total_t    pn_w;
    tou_pkg::total_t    td_w;
    tou_pkg::total_t    tn_w;
    tou_pkg::out_item_t tick_totals;

    always_comb
    begin
        e         = tou_pkg::mark_t'(item.energy_reading);
        on_hour   = (item.minute == 6'd0) && (item.second == 6'd0);
        clock_set = item.year_since_1900 >= tou_pkg::CLOCK_SET_YEAR;
        real_date = item.year_since_1900 > tou_pkg::CLOCK_SET_YEAR;

        // load any empty mark with the current reading
        filled.last_midnight    = (marks.last_midnight == '0)    ? e : marks.last_midnight;
        filled.cur_midnight     = (marks.cur_midnight == '0)     ? e : marks.cur_midnight;
        filled.last_day_start   = (marks.last_day_start == '0)   ? e : marks.last_day_start;
        filled.last_night_start = (marks.last_night_start == '0) ? e : marks.last_night_start;
        filled.cur_day_start    = (marks.cur_day_start == '0)    ? e : marks.cur_day_start;
        filled.cur_night_start  = (marks.cur_night_start == '0)  ? e : marks.cur_night_start;

        // one roll per tick, midnight first
        rolled = filled;
        if ((item.hour == 5'd0) && on_hour && real_date)
        begin
            rolled.last_midnight    = filled.cur_midnight;
            rolled.cur_midnight     = e;
            rolled.last_day_start   = filled.cur_day_start;
            rolled.last_night_start = filled.cur_night_start;
        end
        else if ((item.hour == cfg.day_start_hour) && on_hour)
        begin
            rolled.last_day_start = filled.cur_day_start;
            rolled.cur_day_start  = e;
        end
        else if ((item.hour == cfg.night_start_hour) && on_hour)
        begin
            rolled.last_night_start = filled.cur_night_start;
            rolled.cur_night_start  = e;
        end

        // keep yesterday's marks in time order
        clamped = rolled;
        clamped.last_day_start = (rolled.last_day_start < rolled.last_midnight)
                               ? rolled.last_midnight : rolled.last_day_start;
        night_min = (rolled.last_night_start < rolled.last_midnight)
                  ? rolled.last_midnight : rolled.last_night_start;
        clamped.last_night_start = (night_min < clamped.last_day_start)
                                 ? clamped.last_day_start : night_min;

        e_w  = tou_pkg::TOTAL_BITS'(e);
        pm_w = tou_pkg::TOTAL_BITS'(clamped.last_midnight);
        tm_w = tou_pkg::TOTAL_BITS'(clamped.cur_midnight);
        pd_w = tou_pkg::TOTAL_BITS'(clamped.last_day_start);
        pn_w = tou_pkg::TOTAL_BITS'(clamped.last_night_start);
        td_w = tou_pkg::TOTAL_BITS'(clamped.cur_day_start);
        tn_w = tou_pkg::TOTAL_BITS'(clamped.cur_night_start);

        tick_totals.used_today      = e_w - tm_w;
        tick_totals.yesterday_total = (tm_w <= pm_w) ? '0 : tm_w - pm_w;
        tick_totals.yesterday_night = pd_w - pm_w + tm_w - pn_w;
        tick_totals.yesterday_day   = (pn_w > pd_w) ? pn_w - pd_w : '0;
        tick_totals.night_today     = totals.night_today;
        tick_totals.day_today       = totals.day_today;
        if (real_date)
        begin
            if (item.hour < cfg.day_start_hour)
            begin
                tick_totals.night_today = e_w - tm_w;
                tick_totals.day_today   = '0;
            end
            else if (item.hour < cfg.night_start_hour)
            begin
                tick_totals.night_today = td_w - tm_w;
                tick_totals.day_today   = e_w - td_w;
            end
            else
            begin
                tick_totals.night_today = td_w - tm_w + e_w - tn_w;
                tick_totals.day_today   = tn_w - td_w;
            end
        end

        marks_next  = marks;
        totals_next = totals;
        case (item.op)
            tou_pkg::OP_TICK:
            begin
                if (clock_set)
                begin
                    marks_next  = clamped;
                    totals_next = tick_totals;
                end
                else
                begin
                    marks_next = filled;
                end
            end
            tou_pkg::OP_CLR_PREV:
            begin
                marks_next.last_midnight    = '0;
                marks_next.last_day_start   = '0;
                marks_next.last_night_start = '0;
            end
            tou_pkg::OP_CLR_ALL:
            begin
                marks_next = '0;
            end
            default:
            begin
                marks_next = marks;
            end
        endcase
    end

endmodule

// ===== dv/tou_split_checker.sv =====
`timescale 1ns / 1ps
// tou_split_checker: watches the tick, totals and apb channels of the energy split unit
// predicts the six consumption totals per tick and compares them; depends on tou_pkg
module tou_split_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    tou_tick_if                            tick,
    tou_total_if                           totals,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [tou_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [tou_pkg::APB_WIDTH-1:0]  pwdata,
    output int unsigned                    pending_results,
    output int unsigned                    fault_count
);
    import tou_pkg::*;

    marks_t               marks;
    out_item_t            zone_sums;
    logic [HOUR_BITS-1:0] day_hour;
    logic [HOUR_BITS-1:0] night_hour;
    out_item_t            expected_totals[$];
    out_item_t            want;
    int unsigned          result_index;

    task automatic report_fault(input string msg);
        if (fault_count < 100)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input total_t got, input total_t exp_val);
        if (got !== exp_val)
            report_fault($sformatf("result %0d %s got %0d want %0d",
                                   result_index, name, got, exp_val));
    endtask

    // advances the marks and totals by one item and returns the totals after it
    task automatic account_item(input in_item_t it, output out_item_t res);
        mark_t  e;
        logic   on_hour;
        logic   real_date;
        total_t ev, pm, tm, pds, pns, tds, tns;
        if (it.op == OP_TICK)
        begin
            e         = it.energy_reading;
            on_hour   = (it.minute == 6'd0) && (it.second == 6'd0);
            real_date = it.year_since_1900 > CLOCK_SET_YEAR;
            if (marks.cur_midnight == '0)     marks.cur_midnight     = e;
            if (marks.cur_day_start == '0)    marks.cur_day_start    = e;
            if (marks.cur_night_start == '0)  marks.cur_night_start  = e;
            if (marks.last_midnight == '0)    marks.last_midnight    = e;
            if (marks.last_day_start == '0)   marks.last_day_start   = e;
            if (marks.last_night_start == '0) marks.last_night_start = e;
            if (it.year_since_1900 >= CLOCK_SET_YEAR)
            begin
                if (it.hour == 5'd0 && on_hour && real_date)
                begin
                    marks.last_midnight    = marks.cur_midnight;
                    marks.cur_midnight     = e;
                    marks.last_day_start   = marks.cur_day_start;
                    marks.last_night_start = marks.cur_night_start;
                end
                else if (it.hour == day_hour && on_hour)
                begin
                    marks.last_day_start = marks.cur_day_start;
                    marks.cur_day_start  = e;
                end
                else if (it.hour == night_hour && on_hour)
                begin
                    marks.last_night_start = marks.cur_night_start;
                    marks.cur_night_start  = e;
                end
                if (marks.last_day_start < marks.last_midnight)
                    marks.last_day_start = marks.last_midnight;
                if (marks.last_night_start < marks.last_midnight)
                    marks.last_night_start = marks.last_midnight;
                if (marks.last_night_start < marks.last_day_start)
                    marks.last_night_start = marks.last_day_start;
                ev  = total_t'(e);
                pm  = total_t'(marks.last_midnight);
                tm  = total_t'(marks.cur_midnight);
                pds = total_t'(marks.last_day_start);
                pns = total_t'(marks.last_night_start);
                tds = total_t'(marks.cur_day_start);
                tns = total_t'(marks.cur_night_start);
                zone_sums.used_today      = ev - tm;
                zone_sums.yesterday_total = (tm <= pm) ? '0 : tm - pm;
                zone_sums.yesterday_night = pds - pm + tm - pns;
                zone_sums.yesterday_day   = (pns > pds) ? pns - pds : '0;
                if (real_date)
                begin
                    if (it.hour < day_hour)
                    begin
                        zone_sums.night_today = ev - tm;
                        zone_sums.day_today   = '0;
                    end
                    else if (it.hour < night_hour)
                    begin
                        zone_sums.night_today = tds - tm;
                        zone_sums.day_today   = ev - tds;
                    end
                    else
                    begin
                        zone_sums.night_today = tds - tm + ev - tns;
                        zone_sums.day_today   = tns - tds;
                    end
                end
            end
        end
        else if (it.op == OP_CLR_PREV || it.op == OP_CLR_ALL)
        begin
            if (it.op == OP_CLR_ALL)
            begin
                marks.cur_midnight    = '0;
                marks.cur_day_start   = '0;
                marks.cur_night_start = '0;
            end
            marks.last_midnight    = '0;
            marks.last_day_start   = '0;
            marks.last_night_start = '0;
        end
        res = zone_sums;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks      = '0;
            zone_sums  = '0;
            day_hour   = DAY_START_RESET;
            night_hour = NIGHT_START_RESET;
            expected_totals.delete();
            result_index = 0;
            fault_count  = 0;
            pending_results <= 0;
        end
        else
        begin
            if (totals.valid && totals.ready)
            begin
                if (expected_totals.size() == 0)
                    report_fault($sformatf("result %0d with no tick waiting", result_index));
                else
                begin
                    want = expected_totals.pop_front();
                    check_field("used_today",      totals.data.used_today,      want.used_today);
                    check_field("yesterday_total", totals.data.yesterday_total,
                                want.yesterday_total);
                    check_field("yesterday_night", totals.data.yesterday_night,
                                want.yesterday_night);
                    check_field("yesterday_day",   totals.data.yesterday_day,
                                want.yesterday_day);
                    check_field("night_today",     totals.data.night_today,     want.night_today);
                    check_field("day_today",       totals.data.day_today,       want.day_today);
                end
                result_index++;
            end
            if (tick.valid && tick.ready)
            begin
                account_item(tick.data, want);
                expected_totals.push_back(want);
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[ADDR_BITS-1:2] == REG_DAY_START)
                    day_hour = pwdata[HOUR_BITS-1:0];
                else
                    night_hour = pwdata[HOUR_BITS-1:0];
            end
            pending_results <= expected_totals.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: top of the energy split unit bench; drives ticks, totals ready and apb writes
// depends on tou_pkg, tou_tick_if, tou_total_if, tou_split_checker and the unit itself
module testbench;
    import tou_pkg::*;

    // op code the unit must treat as a no-op
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    // cycles without any transfer before the run is declared hung
    localparam int         IDLE_LIMIT = 3000;
    localparam int         PHASE_ITEMS = 65;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [APB_WIDTH-1:0] pwdata;
    logic [APB_WIDTH-1:0] prdata;
    logic                 pready;

    int unsigned          pending_results;
    int unsigned          fault_count;
    int unsigned          idle_cycles;
    int unsigned          burst_left;

    // hours as last programmed, steer the roll times the stimulus aims at
    logic [HOUR_BITS-1:0] day_hour   = DAY_START_RESET;
    logic [HOUR_BITS-1:0] night_hour = NIGHT_START_RESET;
    // running meter value, mostly climbs like a real meter
    mark_t                meter_wh;

    tou_tick_if  tick ();
    tou_total_if totals ();

    time_of_use_energy_split_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .totals  (totals),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tou_split_checker split_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick            (tick),
        .totals          (totals),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pending_results (pending_results),
        .fault_count     (fault_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: any tick or totals transfer restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (tick.valid && tick.ready) || (totals.valid && totals.ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // totals receiver: stretches of always ready, coin flips and heavy stall
    initial
    begin
        int unsigned mode;
        int unsigned span;
        totals.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(4, 60);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0:       totals.ready <= 1'b1;
                    1:       totals.ready <= 1'($urandom_range(0, 1));
                    default: totals.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic in_item_t item_of(input logic [1:0] op, input mark_t e,
                                         input logic [4:0] h, input logic [5:0] m,
                                         input logic [5:0] s, input logic [7:0] y);
        in_item_t it;
        it.op              = op;
        it.energy_reading  = e;
        it.hour            = h;
        it.minute          = m;
        it.second          = s;
        it.year_since_1900 = y;
        return it;
    endfunction

    // random item: mostly ticks at or near roll times on a set clock
    function automatic in_item_t make_item();
        in_item_t    it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            it.op = OP_CLR_PREV;
        else if (pick < 8)
            it.op = OP_CLR_ALL;
        else if (pick < 9)
            it.op = OP_UNUSED;
        else
            it.op = OP_TICK;

        pick = $urandom_range(0, 99);
        if (pick < 85)
            meter_wh = meter_wh + mark_t'($urandom_range(0, 3000));
        else if (pick < 90)
            meter_wh = mark_t'($urandom());
        else if (pick < 95)
            meter_wh = '0;
        else
            meter_wh = 24'hFF_FFFF - mark_t'($urandom_range(0, 500));
        it.energy_reading = meter_wh;

        pick = $urandom_range(0, 99);
        if (pick < 25)
            it.hour = 5'd0;
        else if (pick < 45)
            it.hour = day_hour;
        else if (pick < 65)
            it.hour = night_hour;
        else
            it.hour = 5'($urandom_range(0, 23));

        if ($urandom_range(0, 9) < 7)
        begin
            it.minute = 6'd0;
            it.second = 6'd0;
        end
        else
        begin
            it.minute = 6'($urandom_range(0, 59));
            it.second = 6'($urandom_range(0, 59));
        end

        pick = $urandom_range(0, 99);
        if (pick < 75)
            it.year_since_1900 = 8'($urandom_range(117, 255));
        else if (pick < 87)
            it.year_since_1900 = CLOCK_SET_YEAR;
        else
            it.year_since_1900 = 8'($urandom_range(0, 115));
        return it;
    endfunction

    // returns at the first edge where every expected result has been transferred
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    // one tick transfer, with a random gap or a full drain between bursts
    task automatic issue(input in_item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 19) == 0)
            begin
                tick.valid <= 1'b0;
                wait_drained();
            end
            else
            begin
                gap = $urandom_range(0, 9);
                if (gap < 4)
                    gap = 0;
                else if (gap < 8)
                    gap = $urandom_range(1, 6);
                else
                    gap = $urandom_range(7, 30);
                if (gap > 0)
                begin
                    tick.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        burst_left--;
        tick.data  <= it;
        tick.valid <= 1'b1;
        do
            @(posedge clk);
        while (!tick.ready);
    endtask

    // both hour registers, back to back; psel stays up between the two writes
    task automatic program_hours(input logic [HOUR_BITS-1:0] day_val,
                                 input logic [HOUR_BITS-1:0] night_val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DAY_START, 2'b00};
        pwdata  <= APB_WIDTH'(day_val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        paddr   <= {REG_NIGHT_START, 2'b00};
        pwdata  <= APB_WIDTH'(night_val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        day_hour   = day_val;
        night_hour = night_val;
    endtask

    initial
    begin
        logic [HOUR_BITS-1:0] phase_day[6];
        logic [HOUR_BITS-1:0] phase_night[6];

        // extremes, swapped zones, equal hours, two random settings, back to reset values
        phase_day   = '{5'd0,  5'd23, 5'd12, 5'd0, 5'd0, DAY_START_RESET};
        phase_night = '{5'd23, 5'd0,  5'd12, 5'd0, 5'd0, NIGHT_START_RESET};
        phase_day[3]   = 5'($urandom_range(0, 23));
        phase_night[3] = 5'($urandom_range(0, 23));
        phase_day[4]   = 5'($urandom_range(0, 23));
        phase_night[4] = 5'($urandom_range(0, 23));

        rst_n      = 1'b0;
        tick.valid = 1'b0;
        tick.data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        meter_wh   = '0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset hours (day 7, night 23)
        // first tick fills every mark, clock set at 05:30, before the day start hour
        issue(item_of(OP_TICK, 24'd1000, 5'd5, 6'd30, 6'd10, 8'd120));
        // clock not set: zero reading, year zero, then the last unset year
        issue(item_of(OP_TICK, 24'd0, 5'd0, 6'd0, 6'd0, 8'd0));
        issue(item_of(OP_TICK, 24'd2000, 5'd0, 6'd0, 6'd0, 8'd115));
        // midnight, day start and night start rolls on a set clock
        issue(item_of(OP_TICK, 24'd3000, 5'd0, 6'd0, 6'd0, 8'd117));
        issue(item_of(OP_TICK, 24'd4000, 5'd7, 6'd0, 6'd0, 8'd255));
        issue(item_of(OP_TICK, 24'd5000, 5'd12, 6'd34, 6'd56, 8'd200));
        issue(item_of(OP_TICK, 24'd6000, 5'd23, 6'd0, 6'd0, 8'd130));
        issue(item_of(OP_TICK, 24'hFF_FFFF, 5'd23, 6'd59, 6'd59, 8'd255));
        // year exactly at the threshold: no midnight roll, today zones frozen
        issue(item_of(OP_TICK, 24'd7000, 5'd0, 6'd0, 6'd0, CLOCK_SET_YEAR));
        issue(item_of(OP_TICK, 24'd8000, 5'd7, 6'd0, 6'd0, CLOCK_SET_YEAR));
        // raw time fields past their legal range never match a roll time
        issue(item_of(OP_TICK, 24'd9000, 5'd31, 6'd63, 6'd63, 8'd140));
        issue(item_of(OP_TICK, 24'd9500, 5'd24, 6'd0, 6'd0, 8'd140));
        // reading below the marks, differences wrap
        issue(item_of(OP_TICK, 24'd10, 5'd0, 6'd0, 6'd0, 8'd118));
        issue(item_of(OP_CLR_PREV, 24'hABCDEF, 5'd31, 6'd63, 6'd63, 8'd255));
        issue(item_of(OP_TICK, 24'd12000, 5'd3, 6'd0, 6'd0, 8'd150));
        issue(item_of(OP_CLR_ALL, 24'h54_3210, 5'd16, 6'd32, 6'd32, 8'd128));
        issue(item_of(OP_TICK, 24'd13000, 5'd0, 6'd0, 6'd0, 8'd150));
        issue(item_of(OP_UNUSED, 24'h80_0000, 5'd0, 6'd0, 6'd0, 8'd150));
        // one second or one minute past the hour is not on the hour
        issue(item_of(OP_TICK, 24'd14000, 5'd0, 6'd0, 6'd1, 8'd150));
        issue(item_of(OP_TICK, 24'd15000, 5'd7, 6'd1, 6'd0, 8'd150));
        issue(item_of(OP_TICK, 24'd16000, 5'd22, 6'd0, 6'd0, 8'd150));
        issue(item_of(OP_TICK, 24'd17000, 5'd23, 6'd0, 6'd0, 8'd150));
        meter_wh = 24'd17000;

        // random phases, each under its own hour setting; hours change only when drained
        for (int p = 0; p < 6; p++)
        begin
            tick.valid <= 1'b0;
            wait_drained();
            program_hours(phase_day[p], phase_night[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
                issue(make_item());
        end

        tick.valid <= 1'b0;
        wait_drained();
        // idle wait in case something stray comes out of the pipeline
        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tou_pkg.sv
src/tou_tick_if.sv
src/tou_total_if.sv
src/tou_regs.sv
src/tou_calc.sv
src/time_of_use_energy_split_unit.sv
dv/tou_split_checker.sv
dv/testbench.sv
